@@ sv/assert_macros.svh @@
// Assertion macros for the checker file of the scaler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bis_pkg.sv @@
// Shared widths, register codes and configuration type of the bilinear scaler.
`timescale 1ns / 1ps
package bis_pkg;
  localparam int POS_W   = 12;
  localparam int STEP_W  = 21;
  localparam int SIZE_W  = 9;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 4 * CH_W;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 9'd256;
  localparam logic [STEP_W-1:0] STEP_RST   = 21'd65536;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_STEP   = 2'd2
  } reg_idx_t;

  typedef enum logic {
    KIND_STORE  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  // Sizes are already clamped to 1..MAX by the register block.
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [STEP_W-1:0] step;
  } cfg_t;
endpackage

@@ sv/bis_if.sv @@
// Valid/ready channel interfaces for the scaler's input and result beats.
`timescale 1ns / 1ps
interface bis_in_if;
  import bis_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [CH_W-1:0]   in_alpha;
  logic [CH_W-1:0]   in_red;
  logic [CH_W-1:0]   in_green;
  logic [CH_W-1:0]   in_blue;

  modport source (output valid, kind, pos_x, pos_y, in_alpha, in_red, in_green, in_blue,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_y, in_alpha, in_red, in_green, in_blue,
                output ready);
endinterface

interface bis_out_if;
  import bis_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_alpha;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;

  modport source (output valid, out_alpha, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_alpha, out_red, out_green, out_blue, output ready);
endinterface

@@ sv/bilinear_image_scaler_core.sv @@
// Path: a request passes the position pipeline, the frame store read register and the
// interpolator stages; its result waits in the interpolator's last register until taken.
// Throughput: one beat (store or request) per cycle; each stage holds only when the stage
// after it is full and stalled, so bubbles close up and a waiting result stalls the input
// only once every stage ahead of it is full.
// The depth is set by the restoring divider, one quotient bit per stage, 33 - FRAC_BITS deep.
// Reset (rst, synchronous, active high) empties all stages and loads the registers with
// width 256, height 256 and step 1.0; the frame store keeps no reset and is written first.
`timescale 1ns / 1ps
module bilinear_image_scaler_core #(
  parameter int MAX_WIDTH  = bis_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bis_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = bis_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bis_pkg::PADDR_W-1:0]  paddr,
  input  logic [bis_pkg::PDATA_W-1:0]  pwdata,
  output logic [bis_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  bis_in_if.sink                       in_ch,
  bis_out_if.source                    out_ch
);
  import bis_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  cfg_t cfg;

  // Position pipeline to frame store.
  logic              loc_valid, loc_ready, loc_kind;
  logic [POS_W-1:0]  loc_pos_x, loc_pos_y;
  logic [PIX_W-1:0]  loc_pix, in_pix;
  logic [FRAC_BITS-1:0] loc_fx, loc_fy;
  logic [XW-1:0]     loc_x0, loc_x1;
  logic [YW-1:0]     loc_y0, loc_y1;

  // Frame store to interpolator.
  logic              mem_valid, mem_ready;
  logic [PIX_W-1:0]  p00, p10, p01, p11;
  logic [FRAC_BITS-1:0] mem_fx, mem_fy;

  logic [PIX_W-1:0]  res_pix;

  // Pixels travel packed alpha, red, green, blue from the top byte down.
  assign in_pix = {in_ch.in_alpha, in_ch.in_red, in_ch.in_green, in_ch.in_blue};

  bis_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // Every beat, store or request, runs the full position pipeline so that a store
  // reaches the frame store ahead of every request that follows it.
  bis_locate #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_locate (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .kind     (in_ch.kind),
    .pos_x    (in_ch.pos_x),
    .pos_y    (in_ch.pos_y),
    .pix      (in_pix),
    .out_valid(loc_valid),
    .out_ready(loc_ready),
    .out_kind (loc_kind),
    .out_pos_x(loc_pos_x),
    .out_pos_y(loc_pos_y),
    .out_pix  (loc_pix),
    .fx       (loc_fx),
    .fy       (loc_fy),
    .x0       (loc_x0),
    .x1       (loc_x1),
    .y0       (loc_y0),
    .y1       (loc_y1)
  );

  // Stores end here; only requests carry on toward the result channel.
  bis_frame_mem #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .in_valid (loc_valid),
    .in_ready (loc_ready),
    .kind     (loc_kind),
    .pos_x    (loc_pos_x),
    .pos_y    (loc_pos_y),
    .pix      (loc_pix),
    .in_fx    (loc_fx),
    .in_fy    (loc_fy),
    .x0       (loc_x0),
    .x1       (loc_x1),
    .y0       (loc_y0),
    .y1       (loc_y1),
    .out_valid(mem_valid),
    .out_ready(mem_ready),
    .p00      (p00),
    .p10      (p10),
    .p01      (p01),
    .p11      (p11),
    .fx       (mem_fx),
    .fy       (mem_fy)
  );

  // The interpolator's last stage is the output register of the result channel.
  bis_interp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_interp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mem_valid),
    .in_ready (mem_ready),
    .p00      (p00),
    .p10      (p10),
    .p01      (p01),
    .p11      (p11),
    .fx       (mem_fx),
    .fy       (mem_fy),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .pix      (res_pix)
  );

  assign out_ch.out_alpha = res_pix[4*CH_W-1:3*CH_W];
  assign out_ch.out_red   = res_pix[3*CH_W-1:2*CH_W];
  assign out_ch.out_green = res_pix[2*CH_W-1:CH_W];
  assign out_ch.out_blue  = res_pix[CH_W-1:0];
endmodule

@@ sv/bis_cfg_regs.sv @@
// APB register block holding source size and step, with size clamping.
`timescale 1ns / 1ps
module bis_cfg_regs #(
  parameter int MAX_WIDTH  = bis_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bis_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bis_pkg::PADDR_W-1:0]  paddr,
  input  logic [bis_pkg::PDATA_W-1:0]  pwdata,
  output logic [bis_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output bis_pkg::cfg_t                cfg
);
  import bis_pkg::*;

  logic [SIZE_W-1:0] src_width;
  logic [SIZE_W-1:0] src_height;
  logic [STEP_W-1:0] src_step;
  reg_idx_t          idx;
  logic              wr;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (int'(v) > maxv) begin
      r = SIZE_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= WIDTH_RST;
      src_height <= HEIGHT_RST;
      src_step   <= STEP_RST;
    end else if (wr) begin
      case (idx)
        REG_WIDTH:  src_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: src_height <= pwdata[SIZE_W-1:0];
        REG_STEP:   src_step   <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = PDATA_W'(src_width);
      REG_HEIGHT: prdata = PDATA_W'(src_height);
      REG_STEP:   prdata = PDATA_W'(src_step);
      default:    prdata = '0;
    endcase
  end

  assign cfg.width  = clamp_size(src_width, MAX_WIDTH);
  assign cfg.height = clamp_size(src_height, MAX_HEIGHT);
  assign cfg.step   = src_step;
endmodule

@@ sv/bis_locate.sv @@
// Position pipeline: coordinate multiply, one-bit-per-stage division, edge mirroring.
`timescale 1ns / 1ps
module bis_locate #(
  parameter int MAX_WIDTH  = bis_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bis_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = bis_pkg::FRAC_BITS_DEF,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bis_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [bis_pkg::POS_W-1:0]   pos_x,
  input  logic [bis_pkg::POS_W-1:0]   pos_y,
  input  logic [bis_pkg::PIX_W-1:0]   pix,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [bis_pkg::POS_W-1:0]   out_pos_x,
  output logic [bis_pkg::POS_W-1:0]   out_pos_y,
  output logic [bis_pkg::PIX_W-1:0]   out_pix,
  output logic [FRAC_BITS-1:0]        fx,
  output logic [FRAC_BITS-1:0]        fy,
  output logic [XW-1:0]               x0,
  output logic [XW-1:0]               x1,
  output logic [YW-1:0]               y0,
  output logic [YW-1:0]               y1
);
  import bis_pkg::*;

  localparam int PROD_W = POS_W + STEP_W;
  localparam int BASE_W = PROD_W - FRAC_BITS;
  localparam int NDIV   = BASE_W;
  localparam int NST    = NDIV + 2;

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  logic              kind_q [0:NST-1];
  logic [POS_W-1:0]  posx_q [0:NST-1];
  logic [POS_W-1:0]  posy_q [0:NST-1];
  logic [PIX_W-1:0]  pix_q  [0:NST-1];
  logic [FRAC_BITS-1:0] fx_q [0:NST-1];
  logic [FRAC_BITS-1:0] fy_q [0:NST-1];

  // Division state: remainder, unshifted dividend bits, last quotient bit.
  logic [SIZE_W-1:0] rx [0:NDIV];
  logic [SIZE_W-1:0] ry [0:NDIV];
  logic [BASE_W-1:0] dx [0:NDIV];
  logic [BASE_W-1:0] dy [0:NDIV];
  logic              qx [0:NDIV];
  logic              qy [0:NDIV];

  logic [SIZE_W-1:0] rx_next [1:NDIV];
  logic [SIZE_W-1:0] ry_next [1:NDIV];
  logic              gx [1:NDIV];
  logic              gy [1:NDIV];

  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  logic [SIZE_W-1:0] mx0, mx1, my0, my1;
  logic [SIZE_W:0]   ax, ay;

  logic [XW-1:0] x0_q, x1_q;
  logic [YW-1:0] y0_q, y1_q;

  function automatic logic [SIZE_W-1:0] fold(input logic odd, input logic [SIZE_W-1:0] r,
                                             input logic [SIZE_W-1:0] c);
    return odd ? SIZE_W'(c - r - SIZE_W'(1)) : r;
  endfunction

  // Quotient parity and remainder of n+1 from those of n.
  function automatic logic [SIZE_W:0] advance(input logic odd, input logic [SIZE_W-1:0] r,
                                              input logic [SIZE_W-1:0] c);
    logic [SIZE_W:0] n;
    logic            wrap;
    n    = {1'b0, r} + (SIZE_W+1)'(1);
    wrap = (n == {1'b0, c});
    return {odd ^ wrap, wrap ? {SIZE_W{1'b0}} : n[SIZE_W-1:0]};
  endfunction

  always_comb begin
    en[NST-1] = !v[NST-1] || out_ready;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end
  assign in_ready = en[0];

  always_comb begin
    prod_x = pos_x * cfg.step;
    prod_y = pos_y * cfg.step;
  end

  always_comb begin
    logic [SIZE_W:0] tx;
    logic [SIZE_W:0] ty;
    for (int s = 1; s <= NDIV; s++) begin
      tx = {rx[s-1], dx[s-1][BASE_W-1]};
      ty = {ry[s-1], dy[s-1][BASE_W-1]};
      gx[s] = tx >= {1'b0, cfg.width};
      gy[s] = ty >= {1'b0, cfg.height};
      rx_next[s] = gx[s] ? SIZE_W'(tx - {1'b0, cfg.width}) : tx[SIZE_W-1:0];
      ry_next[s] = gy[s] ? SIZE_W'(ty - {1'b0, cfg.height}) : ty[SIZE_W-1:0];
    end
  end

  always_comb begin
    ax  = advance(qx[NDIV], rx[NDIV], cfg.width);
    ay  = advance(qy[NDIV], ry[NDIV], cfg.height);
    mx0 = fold(qx[NDIV], rx[NDIV], cfg.width);
    my0 = fold(qy[NDIV], ry[NDIV], cfg.height);
    mx1 = fold(ax[SIZE_W], ax[SIZE_W-1:0], cfg.width);
    my1 = fold(ay[SIZE_W], ay[SIZE_W-1:0], cfg.height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int s = 1; s < NST; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      kind_q[0] <= kind;
      posx_q[0] <= pos_x;
      posy_q[0] <= pos_y;
      pix_q[0]  <= pix;
      fx_q[0]   <= prod_x[FRAC_BITS-1:0];
      fy_q[0]   <= prod_y[FRAC_BITS-1:0];
      dx[0]     <= prod_x[PROD_W-1:FRAC_BITS];
      dy[0]     <= prod_y[PROD_W-1:FRAC_BITS];
      rx[0]     <= '0;
      ry[0]     <= '0;
      qx[0]     <= 1'b0;
      qy[0]     <= 1'b0;
    end
    for (int s = 1; s < NST; s++) begin
      if (en[s]) begin
        kind_q[s] <= kind_q[s-1];
        posx_q[s] <= posx_q[s-1];
        posy_q[s] <= posy_q[s-1];
        pix_q[s]  <= pix_q[s-1];
        fx_q[s]   <= fx_q[s-1];
        fy_q[s]   <= fy_q[s-1];
      end
    end
    for (int s = 1; s <= NDIV; s++) begin
      if (en[s]) begin
        rx[s] <= rx_next[s];
        ry[s] <= ry_next[s];
        dx[s] <= dx[s-1] << 1;
        dy[s] <= dy[s-1] << 1;
        qx[s] <= gx[s];
        qy[s] <= gy[s];
      end
    end
    if (en[NST-1]) begin
      x0_q <= XW'(mx0);
      x1_q <= XW'(mx1);
      y0_q <= YW'(my0);
      y1_q <= YW'(my1);
    end
  end

  assign out_valid = v[NST-1];
  assign out_kind  = kind_q[NST-1];
  assign out_pos_x = posx_q[NST-1];
  assign out_pos_y = posy_q[NST-1];
  assign out_pix   = pix_q[NST-1];
  assign fx        = fx_q[NST-1];
  assign fy        = fy_q[NST-1];
  assign x0        = x0_q;
  assign x1        = x1_q;
  assign y0        = y0_q;
  assign y1        = y1_q;
endmodule

@@ sv/bis_frame_mem.sv @@
// Frame store split into four parity banks; one write or four neighbor reads a beat.
`timescale 1ns / 1ps
module bis_frame_mem #(
  parameter int MAX_WIDTH  = bis_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bis_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = bis_pkg::FRAC_BITS_DEF,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [bis_pkg::POS_W-1:0]   pos_x,
  input  logic [bis_pkg::POS_W-1:0]   pos_y,
  input  logic [bis_pkg::PIX_W-1:0]   pix,
  input  logic [FRAC_BITS-1:0]        in_fx,
  input  logic [FRAC_BITS-1:0]        in_fy,
  input  logic [XW-1:0]               x0,
  input  logic [XW-1:0]               x1,
  input  logic [YW-1:0]               y0,
  input  logic [YW-1:0]               y1,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bis_pkg::PIX_W-1:0]   p00,
  output logic [bis_pkg::PIX_W-1:0]   p10,
  output logic [bis_pkg::PIX_W-1:0]   p01,
  output logic [bis_pkg::PIX_W-1:0]   p11,
  output logic [FRAC_BITS-1:0]        fx,
  output logic [FRAC_BITS-1:0]        fy
);
  import bis_pkg::*;

  localparam int XH     = (XW > 1) ? XW - 1 : 1;
  localparam int YH     = (YW > 1) ? YW - 1 : 1;
  localparam int BA_W   = XH + YH;
  localparam int BDEPTH = 2 ** BA_W;

  logic              en;
  logic              v;
  logic              wen;
  logic [1:0]        wbank;
  logic [BA_W-1:0]   waddr;
  logic [XW-1:0]     wx;
  logic [YW-1:0]     wy;
  logic [PIX_W-1:0]  rd [0:3];
  logic              x0p, x1p, y0p, y1p;
  logic [FRAC_BITS-1:0] fx_q, fy_q;

  assign en       = !v || out_ready;
  assign in_ready = en;

  assign wx    = XW'(pos_x);
  assign wy    = YW'(pos_y);
  assign wen   = in_valid && en && (kind == KIND_STORE) &&
                 (int'(pos_x) < MAX_WIDTH) && (int'(pos_y) < MAX_HEIGHT);
  assign wbank = {wy[0], wx[0]};
  assign waddr = {YH'(wy >> 1), XH'(wx >> 1)};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BID = 2'(b);
    logic [PIX_W-1:0] mem [0:BDEPTH-1];
    logic [XW-1:0]    sx;
    logic [YW-1:0]    sy;
    logic [BA_W-1:0]  raddr;
    logic [PIX_W-1:0] rdata;

    // When both neighbors share a column they share a bank and an address.
    assign sx    = (x0[0] == BID[0]) ? x0 : x1;
    assign sy    = (y0[0] == BID[1]) ? y0 : y1;
    assign raddr = {YH'(sy >> 1), XH'(sx >> 1)};

    always_ff @(posedge clk) begin
      if (wen && (wbank == BID)) mem[waddr] <= pix;
      if (en) rdata <= mem[raddr];
    end
    assign rd[b] = rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid && (kind == KIND_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0p  <= x0[0];
      x1p  <= x1[0];
      y0p  <= y0[0];
      y1p  <= y1[0];
      fx_q <= in_fx;
      fy_q <= in_fy;
    end
  end

  assign out_valid = v;
  assign p00 = rd[{y0p, x0p}];
  assign p10 = rd[{y0p, x1p}];
  assign p01 = rd[{y1p, x0p}];
  assign p11 = rd[{y1p, x1p}];
  assign fx  = fx_q;
  assign fy  = fy_q;
endmodule

@@ sv/bis_interp.sv @@
// Two-stage interpolator: horizontal blend per row, then vertical blend with clamp.
`timescale 1ns / 1ps
module bis_interp #(
  parameter int FRAC_BITS = bis_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bis_pkg::PIX_W-1:0]   p00,
  input  logic [bis_pkg::PIX_W-1:0]   p10,
  input  logic [bis_pkg::PIX_W-1:0]   p01,
  input  logic [bis_pkg::PIX_W-1:0]   p11,
  input  logic [FRAC_BITS-1:0]        fx,
  input  logic [FRAC_BITS-1:0]        fy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bis_pkg::PIX_W-1:0]   pix
);
  import bis_pkg::*;

  localparam int ACC_W = CH_W + FRAC_BITS + 2;

  logic              vh, vv, en_h, en_v;
  logic [PIX_W-1:0]  top_q, bot_q, res_q;
  logic [PIX_W-1:0]  top_d, bot_d, res_d;
  logic [FRAC_BITS-1:0] fy_q;

  // a*(1-f) + b*f written as a*ONE + (b-a)*f, so one multiplier per lane.
  function automatic logic [CH_W-1:0] lerp(input logic [CH_W-1:0] a,
                                           input logic [CH_W-1:0] b,
                                           input logic [FRAC_BITS-1:0] f);
    logic signed [CH_W:0]      d;
    logic signed [FRAC_BITS:0] fs;
    logic signed [ACC_W-1:0]   acc;
    d   = $signed({1'b0, b}) - $signed({1'b0, a});
    fs  = $signed({1'b0, f});
    acc = $signed({2'b00, a, {FRAC_BITS{1'b0}}}) + d * fs;
    if (acc[ACC_W-1:CH_W+FRAC_BITS] != 2'b00) begin
      return {CH_W{1'b1}};
    end
    return acc[CH_W+FRAC_BITS-1:FRAC_BITS];
  endfunction

  assign en_v     = !vv || out_ready;
  assign en_h     = !vh || en_v;
  assign in_ready = en_h;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      top_d[CH_W*k +: CH_W] = lerp(p00[CH_W*k +: CH_W], p10[CH_W*k +: CH_W], fx);
      bot_d[CH_W*k +: CH_W] = lerp(p01[CH_W*k +: CH_W], p11[CH_W*k +: CH_W], fx);
      res_d[CH_W*k +: CH_W] = lerp(top_q[CH_W*k +: CH_W], bot_q[CH_W*k +: CH_W], fy_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vh <= 1'b0;
      vv <= 1'b0;
    end else begin
      if (en_h) vh <= in_valid;
      if (en_v) vv <= vh;
    end
  end

  always_ff @(posedge clk) begin
    if (en_h) begin
      top_q <= top_d;
      bot_q <= bot_d;
      fy_q  <= fy;
    end
    if (en_v) res_q <= res_d;
  end

  assign out_valid = vv;
  assign pix       = res_q;
endmodule

@@ sv/bis_checker.sv @@
// Port-level checker for the scaler core and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bis_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_kind,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bis_pkg::PIX_W-1:0] out_pix
);
  import bis_pkg::*;

  logic [7:0] pending;
  logic       req_take, res_take;

  assign req_take = in_valid && in_ready && (in_kind == KIND_SAMPLE);
  assign res_take = out_valid && out_ready;

  // Requests taken and not yet answered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(req_take) - 8'(res_take);
    end
  end

  `ASSERT_IMPL(a_no_orphan_result, out_valid, pending != 8'd0, "result beat without open request")
  `ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_pix), "stalled result changed")
  `ASSERT_IMPL(a_reset_empties, $past(rst), !out_valid, "result beat right after reset")
endmodule

bind bilinear_image_scaler_core bis_checker u_bis_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .in_kind  (in_ch.kind),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_pix  ({out_ch.out_alpha, out_ch.out_red, out_ch.out_green, out_ch.out_blue})
);

@@ dv/tb.sv @@
// Self-checking testbench for the bilinear image scaler core.
`timescale 1ns / 1ps
module tb;
  import bis_pkg::*;

  // One input beat as the sender offers it.
  typedef struct {
    kind_t            kind;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [CH_W-1:0]  a;
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
  } pix_beat_t;

  // One resampled RGBA pixel.
  typedef struct {
    logic [CH_W-1:0] a;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgba_t;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;   // lets the pipeline empty after the last result

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bis_in_if  in_ch();
  bis_out_if out_ch();

  bilinear_image_scaler_core u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Beats waiting to be offered, and resampled pixels waiting to come out.
  pix_beat_t pending_beats[$];
  rgba_t     expected_pixels[$];

  // The predictor's own copy of the frame and of the registers.
  logic [PIX_W-1:0]  frame_mem [MAX_WIDTH_DEF * MAX_HEIGHT_DEF];
  logic [SIZE_W-1:0] cur_width;
  logic [SIZE_W-1:0] cur_height;
  logic [STEP_W-1:0] cur_step;

  int  fail_count;
  int  sender_idle_pct;
  int  receiver_idle_pct;
  bit  beat_taken;
  bit  hold_request;
  bit  hold_done;
  int  hold_left;
  longint cycle_count;

  // Sizes of zero act as one; sizes beyond the store act as the store size.
  function automatic int limit_size(logic [SIZE_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Reflect an index back into 0..c-1; every odd copy of the image runs backward.
  function automatic int reflect(longint unsigned n, int c);
    longint unsigned q;
    int rem;
    q = n / c;
    rem = int'(n % c);
    if (q[0]) return c - 1 - rem;
    return rem;
  endfunction

  // Weighted blend of two channel values by a 16-bit fraction, truncated, capped at 255.
  function automatic logic [CH_W-1:0] blend(logic [CH_W-1:0] p0, logic [CH_W-1:0] p1,
                                            longint unsigned f);
    longint unsigned s;
    s = ((longint'(p0) * ((64'd1 << FRAC_BITS_DEF) - f)) + longint'(p1) * f) >> FRAC_BITS_DEF;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  function automatic rgba_t resample(logic [POS_W-1:0] u, logic [POS_W-1:0] v);
    longint unsigned sx, sy, fx, fy, bx, by;
    int w, h, x0, x1, y0, y1, k;
    logic [PIX_W-1:0] p00, p10, p01, p11;
    logic [CH_W-1:0] ch [4];
    logic [CH_W-1:0] top, bot;
    rgba_t res;
    w = limit_size(cur_width, MAX_WIDTH_DEF);
    h = limit_size(cur_height, MAX_HEIGHT_DEF);
    sx = longint'(u) * cur_step;
    sy = longint'(v) * cur_step;
    bx = sx >> FRAC_BITS_DEF;
    by = sy >> FRAC_BITS_DEF;
    fx = sx & ((64'd1 << FRAC_BITS_DEF) - 1);
    fy = sy & ((64'd1 << FRAC_BITS_DEF) - 1);
    x0 = reflect(bx, w);
    x1 = reflect(bx + 1, w);
    y0 = reflect(by, h);
    y1 = reflect(by + 1, h);
    p00 = frame_mem[y0 * MAX_WIDTH_DEF + x0];
    p10 = frame_mem[y0 * MAX_WIDTH_DEF + x1];
    p01 = frame_mem[y1 * MAX_WIDTH_DEF + x0];
    p11 = frame_mem[y1 * MAX_WIDTH_DEF + x1];
    for (k = 0; k < 4; k++) begin
      top = blend(p00[31-8*k -: 8], p10[31-8*k -: 8], fx);
      bot = blend(p01[31-8*k -: 8], p11[31-8*k -: 8], fx);
      ch[k] = blend(top, bot, fy);
    end
    res.a = ch[0];
    res.r = ch[1];
    res.g = ch[2];
    res.b = ch[3];
    return res;
  endfunction

  // Every accepted input beat updates the frame copy or queues an expected pixel.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      beat_taken = 1'b1;
      if (in_ch.kind == KIND_STORE) begin
        // Stores that land outside the physical store are dropped by the block.
        if (in_ch.pos_x < MAX_WIDTH_DEF && in_ch.pos_y < MAX_HEIGHT_DEF) begin
          frame_mem[in_ch.pos_y * MAX_WIDTH_DEF + in_ch.pos_x] =
            {in_ch.in_alpha, in_ch.in_red, in_ch.in_green, in_ch.in_blue};
        end
      end else begin
        expected_pixels.push_back(resample(in_ch.pos_x, in_ch.pos_y));
      end
    end
  end

  // Sender: a held beat stays until taken; otherwise offer the next one or idle.
  always @(negedge clk) begin
    pix_beat_t nb;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !beat_taken) begin
      in_ch.valid <= 1'b1;
    end else if (pending_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
      nb = pending_beats.pop_front();
      in_ch.valid    <= 1'b1;
      in_ch.kind     <= nb.kind;
      in_ch.pos_x    <= nb.x;
      in_ch.pos_y    <= nb.y;
      in_ch.in_alpha <= nb.a;
      in_ch.in_red   <= nb.r;
      in_ch.in_green <= nb.g;
      in_ch.in_blue  <= nb.b;
    end else begin
      in_ch.valid <= 1'b0;
    end
    beat_taken = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off so the pipeline backs up.
  always @(negedge clk) begin
    if (hold_request && !hold_done) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (rst || hold_left > 0) begin
      out_ch.ready <= 1'b0;
      if (hold_left > 0) hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Result check against the oldest expected pixel.
  always @(posedge clk) begin
    rgba_t exp_pix;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result beat a=%0d r=%0d g=%0d b=%0d", $realtime,
                 out_ch.out_alpha, out_ch.out_red, out_ch.out_green, out_ch.out_blue);
        fail_count++;
      end else begin
        exp_pix = expected_pixels.pop_front();
        if (out_ch.out_alpha !== exp_pix.a) begin
          $display("%0t: alpha expected %0d actual %0d", $realtime, exp_pix.a,
                   out_ch.out_alpha);
          fail_count++;
        end
        if (out_ch.out_red !== exp_pix.r) begin
          $display("%0t: red expected %0d actual %0d", $realtime, exp_pix.r, out_ch.out_red);
          fail_count++;
        end
        if (out_ch.out_green !== exp_pix.g) begin
          $display("%0t: green expected %0d actual %0d", $realtime, exp_pix.g,
                   out_ch.out_green);
          fail_count++;
        end
        if (out_ch.out_blue !== exp_pix.b) begin
          $display("%0t: blue expected %0d actual %0d", $realtime, exp_pix.b,
                   out_ch.out_blue);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_beat(kind_t kind, int x, int y, logic [PIX_W-1:0] argb);
    pix_beat_t nb;
    nb.kind = kind;
    nb.x = POS_W'(x);
    nb.y = POS_W'(y);
    {nb.a, nb.r, nb.g, nb.b} = argb;
    pending_beats.push_back(nb);
  endtask

  // Wait until every beat has gone in, every result is out, and the pipe is empty.
  task automatic wait_quiet();
    forever begin
      @(negedge clk);
      #1;
      if (pending_beats.size() == 0 && !in_ch.valid && expected_pixels.size() == 0) break;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write with setup and access phases; the upper bits of pwdata carry noise the register must drop.
  task automatic reg_write(reg_idx_t idx, logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // New settings: the frame region they cover is written in full before any request.
  task automatic configure(int w, int h, int stp);
    int ew, eh, x, y;
    wait_quiet();
    reg_write(REG_WIDTH,  {$urandom} & ~32'h1FF | (w & 32'h1FF));
    reg_write(REG_HEIGHT, {$urandom} & ~32'h1FF | (h & 32'h1FF));
    reg_write(REG_STEP,   {$urandom} & ~32'h1FFFFF | (stp & 32'h1FFFFF));
    cur_width  = SIZE_W'(w);
    cur_height = SIZE_W'(h);
    cur_step   = STEP_W'(stp);
    ew = limit_size(cur_width, MAX_WIDTH_DEF);
    eh = limit_size(cur_height, MAX_HEIGHT_DEF);
    for (y = 0; y < eh; y++) begin
      for (x = 0; x < ew; x++) push_beat(KIND_STORE, x, y, $urandom);
    end
  endtask

  // Mostly requests at random coordinates, with stores scattered in, some out of range.
  task automatic random_traffic(int n);
    int i, sel;
    for (i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        if ($urandom_range(3) == 0) begin
          push_beat(KIND_SAMPLE, $urandom_range(4095), $urandom_range(4095), $urandom);
        end else begin
          push_beat(KIND_SAMPLE, $urandom_range(63), $urandom_range(63), $urandom);
        end
      end else if (sel < 92) begin
        push_beat(KIND_STORE, $urandom_range(255), $urandom_range(255), $urandom);
      end else begin
        push_beat(KIND_STORE, $urandom_range(4095, 256), $urandom_range(4095), $urandom);
      end
    end
  endtask

  function automatic int pick_step();
    case ($urandom_range(3))
      0: return $urandom_range(1048576, 4096);
      1: return $urandom_range(70000, 60000);
      2: return $urandom_range(32768, 4096);
      default: return 32'h10000 * $urandom_range(4, 1);
    endcase
  endfunction

  initial begin
    int ph;
    fail_count = 0;
    cycle_count = 0;
    beat_taken = 1'b0;
    hold_request = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    sender_idle_pct = 33;
    receiver_idle_pct = 56;
    cur_width  = WIDTH_RST;
    cur_height = HEIGHT_RST;
    cur_step   = STEP_RST;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_STORE;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.in_alpha = '0;
    in_ch.in_red = '0;
    in_ch.in_green = '0;
    in_ch.in_blue = '0;
    out_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: a 2x2 frame of extreme channel values, requests at the corners of the
    // coordinate range, and stores that miss the physical store and must be dropped.
    configure(2, 2, 65536);
    push_beat(KIND_STORE, 0, 0, 32'hFFFF_FFFF);
    push_beat(KIND_STORE, 1, 1, 32'h0000_0000);
    push_beat(KIND_STORE, 4095, 0, 32'h1234_5678);
    push_beat(KIND_STORE, 0, 4095, 32'h1234_5678);
    push_beat(KIND_STORE, 256, 256, 32'h8765_4321);
    push_beat(KIND_SAMPLE, 0, 0, 32'hFFFF_FFFF);
    push_beat(KIND_SAMPLE, 4095, 0, 32'h0);
    push_beat(KIND_SAMPLE, 0, 4095, 32'h0);
    push_beat(KIND_SAMPLE, 4095, 4095, 32'h0);
    push_beat(KIND_SAMPLE, 1, 1, 32'h0);
    // Half-pixel step gives equal weights on both neighbors.
    configure(3, 3, 32768);
    push_beat(KIND_SAMPLE, 1, 1, 32'h0);
    push_beat(KIND_SAMPLE, 3, 5, 32'h0);
    push_beat(KIND_SAMPLE, 4095, 4095, 32'h0);
    // Zero step samples pixel (0,0); width zero acts as one column.
    configure(0, 3, 0);
    push_beat(KIND_SAMPLE, 4095, 4095, 32'h0);
    push_beat(KIND_SAMPLE, 7, 9, 32'h0);
    // Oversized width acts as the store width; the largest step and full step field.
    configure(511, 1, 1048576);
    random_traffic(40);
    configure(1, 256, 4096);
    random_traffic(40);
    configure(256, 1, 2097151);
    random_traffic(40);

    // Random phases with small frames; idling changes with the phase index.
    for (ph = 0; ph < 14; ph++) begin
      if (ph == 5) begin
        sender_idle_pct = 56;
        receiver_idle_pct = 33;
      end else if (ph == 10) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      configure($urandom_range(9), $urandom_range(9), pick_step());
      // Long receiver hold-off while the sender keeps pushing beats.
      if (ph == 11) begin
        hold_request = 1'b1;
        random_traffic(80);
      end else begin
        random_traffic(8);
      end
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
